/* rtl/lhm_pkg.sv */
package lhm_pkg;

   localparam int REQ_DATA_W = 200;
   localparam int RSP_DATA_W = 136;
   localparam int REQ_USER_W = 2;
   localparam int RSP_USER_W = 1;

   localparam int WORD_W      = 32;
   localparam int CHAN_W      = 2;
   localparam int NUM_SUMS    = 1 << CHAN_W;
   localparam int BEACON_W    = 2;
   localparam int OUT_SLOT_W  = 3;
   localparam int WINDOW_SHIFT = 5;
   localparam logic [WORD_W-1:0] SWEEP_RESET = 32'd50000;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] OP_HIT   = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_ELECT = 2'd3;

   localparam logic [BEACON_W-1:0] BEACON_ONE   = 2'd0;
   localparam logic [BEACON_W-1:0] BEACON_TWO   = 2'd1;
   localparam logic [BEACON_W-1:0] BEACON_THREE = 2'd2;

   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_ELECT  = 1'b1;

   typedef enum logic [2:0] {
      CMD_DIRECT,
      CMD_PAIR,
      CMD_TICK,
      CMD_CLEAR,
      CMD_ELECT
   } cmd_op_type;

   typedef struct packed {
      logic [WORD_W-1:0] date;
      logic [WORD_W-1:0] delta;
      logic [WORD_W-1:0] period;
      logic [WORD_W-1:0] thick;
      logic [WORD_W-1:0] prec;
   } hit_type;

   typedef struct packed {
      cmd_op_type          op;
      logic [CHAN_W-1:0]   channel;
      logic [BEACON_W-1:0] beacon;
      hit_type             hit;
   } cmd_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

   typedef struct packed {
      logic                  kind;
      logic [BEACON_W-1:0]   beacon;
      logic [WORD_W-1:0]     date;
      logic [WORD_W-1:0]     delta;
      logic [WORD_W-1:0]     period;
      logic [WORD_W-1:0]     prec;
      logic [OUT_SLOT_W-1:0] slot;
      logic [CHAN_W-1:0]     elected;
   } rsp_type;

endpackage

/* rtl/lhm_front.sv */
module lhm_front (
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [lhm_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [lhm_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                push,
   output lhm_pkg::cmd_type                    cmd
);
   import lhm_pkg::*;

   logic [CHAN_W-1:0] channel;
   hit_type           hit;
   logic [WORD_W-1:0] now_time;
   logic              keep;

   assign channel    = req_tdata[1:0];
   assign hit.date   = req_tdata[33:2];
   assign hit.delta  = req_tdata[65:34];
   assign hit.period = req_tdata[97:66];
   assign hit.thick  = req_tdata[129:98];
   assign hit.prec   = req_tdata[161:130];
   assign now_time   = req_tdata[193:162];

   always_comb begin
      keep        = 1'b1;
      cmd.op      = CMD_ELECT;
      cmd.channel = channel;
      cmd.beacon  = BEACON_THREE;
      cmd.hit     = hit;
      case (req_tuser)
         OP_HIT: begin
            keep = (hit.delta != '0);
            case (channel)
               2'd0: begin
                  cmd.op     = CMD_DIRECT;
                  cmd.beacon = BEACON_TWO;
               end
               2'd1: begin
                  cmd.op     = CMD_DIRECT;
                  cmd.beacon = BEACON_ONE;
               end
               default: begin
                  cmd.op = CMD_PAIR;
               end
            endcase
         end
         OP_TICK: begin
            // carry the tick time in the date slot
            cmd.op       = CMD_TICK;
            cmd.hit.date = now_time;
         end
         OP_CLEAR: begin
            cmd.op = CMD_CLEAR;
         end
         default: begin
            cmd.op = CMD_ELECT;
         end
      endcase
   end

   // drop invalid hits here
   assign push = req_tvalid && req_tready && keep;

endmodule

/* rtl/lhm_queue.sv */
module lhm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lhm_pkg::cmd_type      wr_cmd,
   input  logic                  pop,
   output lhm_pkg::cmd_type      rd_cmd,
   output lhm_pkg::q_status_type status
);
   import lhm_pkg::*;

   localparam logic [QPTR_W:0] FULL_COUNT = (QPTR_W+1)'(QUEUE_DEPTH);

   cmd_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   assign rd_cmd           = mem_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == FULL_COUNT);

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full || pop)
      else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> status.not_empty)
      else $error("queue read while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count out of range");
`endif

endmodule

/* rtl/lhm_back.sv */
module lhm_back #(
   parameter int RING_SLOTS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wen,
   input  logic [lhm_pkg::WORD_W-1:0]   csr_wdata,
   input  lhm_pkg::cmd_type             cmd,
   input  lhm_pkg::q_status_type        q_status,
   output logic                         pop,
   input  logic                         rsp_tready,
   output logic                         rsp_valid,
   output lhm_pkg::rsp_type             rsp_rec
);
   import lhm_pkg::*;

   localparam int SLOT_W = $clog2(RING_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_SLOTS - 1);

   logic [WORD_W-1:0] sweep_ff, sweep_in;
   hit_type           held_ff, held_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [WORD_W-1:0] sums_ff [NUM_SUMS];
   logic [WORD_W-1:0] sums_in [NUM_SUMS];
   logic [CHAN_W-1:0] chosen_ff, chosen_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [WORD_W-1:0] window;
   logic [WORD_W-1:0] age;
   logic              held_busy;
   logic              emit_rec;
   hit_type           emit_hit;
   logic [BEACON_W-1:0] emit_beacon;
   logic [WORD_W-1:0] best;
   logic [CHAN_W-1:0] pick;

   assign window    = sweep_ff >> WINDOW_SHIFT;
   assign age       = cmd.hit.date - held_ff.date;
   assign held_busy = (held_ff.delta != '0);
   assign pop       = q_status.not_empty && (!rsp_valid_ff || rsp_tready);
   assign sweep_in  = csr_wen ? csr_wdata : sweep_ff;

   always_comb begin
      best = '0;
      pick = chosen_ff;
      for (int k = 0; k < NUM_SUMS; k++) begin
         if (sums_ff[k] > best) begin
            best = sums_ff[k];
            pick = CHAN_W'(k);
         end
      end
   end

   always_comb begin
      held_in      = held_ff;
      sums_in      = sums_ff;
      chosen_in    = chosen_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      emit_rec     = 1'b0;
      emit_hit     = cmd.hit;
      emit_beacon  = BEACON_THREE;
      if (pop) begin
         case (cmd.op)
            CMD_DIRECT: begin
               emit_rec    = 1'b1;
               emit_beacon = cmd.beacon;
               sums_in[cmd.channel] = sums_ff[cmd.channel] + cmd.hit.thick;
            end
            CMD_PAIR: begin
               if (held_busy && (age < window)) begin
                  emit_rec = 1'b1;
                  if (cmd.hit.thick < held_ff.thick) begin
                     emit_hit = held_ff;
                  end
                  held_in = '0;
               end else begin
                  held_in = cmd.hit;
               end
               sums_in[cmd.channel] = sums_ff[cmd.channel] + cmd.hit.thick;
            end
            CMD_TICK: begin
               if (held_busy && (age > window)) begin
                  emit_rec = 1'b1;
                  emit_hit = held_ff;
                  held_in  = '0;
               end
            end
            CMD_CLEAR: begin
               for (int k = 0; k < NUM_SUMS; k++) begin
                  sums_in[k] = '0;
               end
            end
            CMD_ELECT: begin
               chosen_in      = pick;
               rsp_valid_in   = 1'b1;
               rsp_in         = '0;
               rsp_in.kind    = KIND_ELECT;
               rsp_in.elected = pick;
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && !rsp_tready;
            end
         endcase
      end
      if (emit_rec) begin
         rsp_valid_in   = 1'b1;
         rsp_in.kind    = KIND_RECORD;
         rsp_in.beacon  = emit_beacon;
         rsp_in.date    = emit_hit.date;
         rsp_in.delta   = emit_hit.delta;
         rsp_in.period  = emit_hit.period;
         rsp_in.prec    = emit_hit.prec;
         rsp_in.slot    = OUT_SLOT_W'(slot_ff);
         rsp_in.elected = '0;
         slot_in        = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= SWEEP_RESET;
         held_ff      <= '0;
         slot_ff      <= '0;
         chosen_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_SUMS; k++) begin
            sums_ff[k] <= '0;
         end
      end else begin
         sweep_ff     <= sweep_in;
         held_ff      <= held_in;
         slot_ff      <= slot_in;
         chosen_ff    <= chosen_in;
         rsp_valid_ff <= rsp_valid_in;
         sums_ff      <= sums_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rec   = rsp_ff;

endmodule

/* rtl/laser_hit_merge_and_channel_elect_top.sv */
// channel  direction  handshake                 payload
// req      in         req_tvalid / req_tready   req_tdata, req_tuser (op)
// rsp      out        rsp_tvalid / rsp_tready   rsp_tdata, rsp_tuser (kind)
// csr      in         csr_wen                   csr_wdata (sweep_period)
//
// One word per cycle while req_tready is high; a word is registered in the command queue,
// and any result it yields is then registered in the output register of the back end.
// A four-entry command queue sits between the front end and the back end.
// Reset is synchronous; no clearing pass.
// rsp_tready low holds the output register; req_tready drops once four words wait.
module laser_hit_merge_and_channel_elect_top #(
   parameter int RING_SLOTS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // channel, hit_date, hit_delta_t, hit_period, hit_thickness, hit_precision, now_time
   input  logic [lhm_pkg::REQ_DATA_W-1:0]     req_tdata,
   // op
   input  logic [lhm_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // beacon_id, rec_date, rec_delta_t, rec_period, rec_precision, ring_slot,
   // elected_channel
   output logic [lhm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // kind
   output logic [lhm_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  logic                               csr_wen,
   input  logic [lhm_pkg::WORD_W-1:0]         csr_wdata
);
   import lhm_pkg::*;

   cmd_type      front_cmd;
   cmd_type      head_cmd;
   logic         push;
   logic         pop;
   q_status_type q_status;
   rsp_type      rec;

   assign req_tready = !q_status.full;

   lhm_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .cmd        (front_cmd)
   );

   lhm_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wr_cmd (front_cmd),
      .pop    (pop),
      .rd_cmd (head_cmd),
      .status (q_status)
   );

   lhm_back #(
      .RING_SLOTS (RING_SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .cmd        (head_cmd),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_rec    (rec)
   );

   assign rsp_tdata = {1'b0, rec.elected, rec.slot, rec.prec, rec.period,
                       rec.delta, rec.date, rec.beacon};
   assign rsp_tuser = rec.kind;

endmodule
